@@ design/trbq_pkg.sv @@
// shared types and constants of the timestamped byte release queue
`timescale 1ns / 1ps
package trbq_pkg;

	localparam int TIME_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 2;
	localparam int MAX_RESULTS = 64;

	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUMP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REBASE = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_SHIFT,
		OP_REBASE
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_PUMP
	} state_t;

	typedef struct packed {
		logic              full;
		logic              head_due;
		logic              next_due;
		logic [BYTE_W-1:0] head_data;
	} chain_stat_t;

endpackage

@@ design/trbq_cell.sv @@
// one queue slot: holds a time and a byte, inserts, shifts and rebases
`timescale 1ns / 1ps
module trbq_cell (
	input  logic                         clk,
	input  trbq_pkg::cell_op_t           op,
	input  logic [trbq_pkg::TIME_W-1:0]  key,
	input  logic [trbq_pkg::BYTE_W-1:0]  new_data,
	input  logic                         occ,
	input  logic                         left_gt,
	input  logic [trbq_pkg::TIME_W-1:0]  left_time,
	input  logic [trbq_pkg::BYTE_W-1:0]  left_data,
	input  logic [trbq_pkg::TIME_W-1:0]  right_time,
	input  logic [trbq_pkg::BYTE_W-1:0]  right_data,
	output logic [trbq_pkg::TIME_W-1:0]  cell_time,
	output logic [trbq_pkg::BYTE_W-1:0]  cell_data,
	output logic                         gt
);

	logic [trbq_pkg::TIME_W-1:0] time_q;
	logic [trbq_pkg::BYTE_W-1:0] data_q;
	logic                        above;

	assign above     = time_q > key;
	assign gt        = occ && above;
	assign cell_time = time_q;
	assign cell_data = data_q;

	always_ff @(posedge clk) begin
		case (op)
			trbq_pkg::OP_PUSH: begin
				if (left_gt) begin
					time_q <= left_time;
					data_q <= left_data;
				end else if (gt || !occ) begin
					time_q <= key;
					data_q <= new_data;
				end
			end
			trbq_pkg::OP_SHIFT: begin
				time_q <= right_time;
				data_q <= right_data;
			end
			trbq_pkg::OP_REBASE: begin
				time_q <= above ? (time_q - key) : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/trbq_chain.sv @@
// row of queue cells with the fill count
`timescale 1ns / 1ps
module trbq_chain #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  trbq_pkg::cell_op_t           op,
	input  logic [trbq_pkg::TIME_W-1:0]  key,
	input  logic [trbq_pkg::BYTE_W-1:0]  new_data,
	output trbq_pkg::chain_stat_t        stat
);

	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [FILL_W-1:0]           fill_q;
	logic [DEPTH-1:0]            occ;
	logic [DEPTH-1:0]            gt;
	logic [trbq_pkg::TIME_W-1:0] time_w [DEPTH];
	logic [trbq_pkg::BYTE_W-1:0] data_w [DEPTH];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                        l_gt;
			logic [trbq_pkg::TIME_W-1:0] l_time;
			logic [trbq_pkg::BYTE_W-1:0] l_data;
			logic [trbq_pkg::TIME_W-1:0] r_time;
			logic [trbq_pkg::BYTE_W-1:0] r_data;

			assign occ[i] = FILL_W'(i) < fill_q;

			if (i == 0) begin : g_first
				assign l_gt   = 1'b0;
				assign l_time = '0;
				assign l_data = '0;
			end else begin : g_mid
				assign l_gt   = gt[i-1];
				assign l_time = time_w[i-1];
				assign l_data = data_w[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign r_time = time_w[i];
				assign r_data = data_w[i];
			end else begin : g_inner
				assign r_time = time_w[i+1];
				assign r_data = data_w[i+1];
			end

			trbq_cell u_cell (
				.clk        (clk),
				.op         (op),
				.key        (key),
				.new_data   (new_data),
				.occ        (occ[i]),
				.left_gt    (l_gt),
				.left_time  (l_time),
				.left_data  (l_data),
				.right_time (r_time),
				.right_data (r_data),
				.cell_time  (time_w[i]),
				.cell_data  (data_w[i]),
				.gt         (gt[i])
			);
		end
	endgenerate

	assign stat.full      = fill_q == FILL_W'(DEPTH);
	assign stat.head_due  = occ[0] && !gt[0];
	assign stat.next_due  = occ[1] && !gt[1];
	assign stat.head_data = data_w[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			case (op)
				trbq_pkg::OP_PUSH:  fill_q <= fill_q + FILL_W'(1);
				trbq_pkg::OP_SHIFT: fill_q <= fill_q - FILL_W'(1);
				default: begin
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill count above depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		op == trbq_pkg::OP_PUSH |-> !stat.full)
		else $error("push into full chain");

	a_shift_head: assert property (@(posedge clk) disable iff (!arst_n)
		op == trbq_pkg::OP_SHIFT |-> stat.head_due)
		else $error("shift without a due head");

endmodule

@@ design/timestamped_byte_release_queue_top.sv @@
// top level of the timestamped byte release queue
`timescale 1ns / 1ps
// Time-ordered byte queue of QUEUE_DEPTH slots, kept as a chain of cells.
// A push or a rebase is taken and the next transfer may follow at once; a
// push into a full queue gives a single overflow result. A pump is accepted
// and then releases the due bytes (at most 64), or ends when nothing is due;
// the head cell hands out one byte a cycle while the output is not stalled,
// while the whole chain shifts toward it. No input is taken during a
// pump or while a result waits under stall. No clearing pass after reset.
module timestamped_byte_release_queue_top #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [trbq_pkg::KIND_W-1:0]  kind,
	input  logic [trbq_pkg::TIME_W-1:0]  time_value,
	input  logic [trbq_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         final_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [trbq_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last_released,
	output logic                         overflow
);

	localparam int CNT_W = $clog2(trbq_pkg::MAX_RESULTS + 1);

	trbq_pkg::state_t            state_q, state_d;
	trbq_pkg::cell_op_t          op;
	trbq_pkg::chain_stat_t       stat;
	logic [trbq_pkg::TIME_W-1:0] key;
	logic [trbq_pkg::TIME_W-1:0] now_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        in_xfer;
	logic                        out_free;
	logic                        load;
	logic                        load_last;
	logic                        load_ovf;
	logic                        pump_done;
	logic                        out_valid_q;
	logic [trbq_pkg::BYTE_W-1:0] out_byte_q;
	logic                        last_q;
	logic                        ovf_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q == trbq_pkg::ST_PUMP) || !out_free;
	assign in_xfer  = in_valid && !in_stall;

	trbq_chain #(
		.DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.key      (key),
		.new_data (data_byte),
		.stat     (stat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			trbq_pkg::ST_IDLE: begin
				if (in_xfer && kind == trbq_pkg::KIND_PUMP) begin
					state_d = trbq_pkg::ST_PUMP;
				end
			end
			trbq_pkg::ST_PUMP: begin
				if (pump_done) begin
					state_d = trbq_pkg::ST_IDLE;
				end
			end
			default: state_d = trbq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		op        = trbq_pkg::OP_HOLD;
		key       = time_value;
		load      = 1'b0;
		load_last = 1'b0;
		load_ovf  = 1'b0;
		pump_done = 1'b0;
		case (state_q)
			trbq_pkg::ST_IDLE: begin
				if (in_xfer) begin
					case (kind)
						trbq_pkg::KIND_PUSH: begin
							if (stat.full) begin
								load      = 1'b1;
								load_last = 1'b1;
								load_ovf  = 1'b1;
							end else begin
								op = trbq_pkg::OP_PUSH;
							end
						end
						trbq_pkg::KIND_REBASE: op = trbq_pkg::OP_REBASE;
						default: begin
						end
					endcase
				end
			end
			trbq_pkg::ST_PUMP: begin
				key = now_q;
				if (out_free) begin
					if (stat.head_due) begin
						op        = trbq_pkg::OP_SHIFT;
						load      = 1'b1;
						load_last = !stat.next_due ||
							cnt_q == CNT_W'(trbq_pkg::MAX_RESULTS - 1);
						pump_done = load_last;
					end else begin
						pump_done = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trbq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				cnt_q <= '0;
			end else if (op == trbq_pkg::OP_SHIFT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_q <= time_value;
		end
		if (load) begin
			out_byte_q <= load_ovf ? '0 : stat.head_data;
			last_q     <= load_last;
			ovf_q      <= load_ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last_released = last_q;
	assign overflow      = ovf_q;

	a_ovf_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last_released && out_byte == '0)
		else $error("malformed overflow result");

	a_pump_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == trbq_pkg::ST_PUMP && load && load_last |=> state_q == trbq_pkg::ST_IDLE)
		else $error("pump kept running after last byte");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(trbq_pkg::MAX_RESULTS))
		else $error("release burst over limit");

endmodule

@@ sim/tb_top.sv @@
// testbench of the timestamped byte release queue: directed and random transfers, scoreboard check
`timescale 1ns / 1ps
module tb_top;

	localparam logic [trbq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int DEPTH = 64;

	typedef struct packed {
		logic [trbq_pkg::BYTE_W-1:0] data;
		logic                        is_last;
		logic                        is_ovf;
	} emit_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [trbq_pkg::KIND_W-1:0] kind = '0;
	logic [trbq_pkg::TIME_W-1:0] time_value = '0;
	logic [trbq_pkg::BYTE_W-1:0] data_byte = '0;
	logic                        final_byte = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [trbq_pkg::BYTE_W-1:0] out_byte;
	logic                        last_released;
	logic                        overflow;

	// shadow of the queue contents, kept sorted by release time
	logic [trbq_pkg::TIME_W-1:0] shadow_time[$];
	logic [trbq_pkg::BYTE_W-1:0] shadow_data[$];
	emit_t                       awaited_out[$];
	emit_t                       head_emit;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;

	timestamped_byte_release_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.time_value(time_value),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_released(last_released),
		.overflow(overflow)
	);

	always #2 clk = ~clk;

	task automatic order_and_release(input logic [trbq_pkg::KIND_W-1:0] k,
			input logic [trbq_pkg::TIME_W-1:0] tv, input logic [trbq_pkg::BYTE_W-1:0] b);
		int pos;
		int n;
		emit_t e;
		case (k)
			trbq_pkg::KIND_PUSH: begin
				if (shadow_time.size() >= DEPTH) begin
					e.data = '0;
					e.is_last = 1'b1;
					e.is_ovf = 1'b1;
					awaited_out.insert(awaited_out.size(), e);
				end else begin
					pos = shadow_time.size();
					while (pos > 0 && shadow_time[pos-1] > tv)
						pos--;
					shadow_time.insert(pos, tv);
					shadow_data.insert(pos, b);
				end
			end
			trbq_pkg::KIND_PUMP: begin
				n = 0;
				while (n < shadow_time.size() && n < trbq_pkg::MAX_RESULTS &&
						shadow_time[n] <= tv) begin
					e.data = shadow_data[n];
					e.is_last = 1'b0;
					e.is_ovf = 1'b0;
					awaited_out.insert(awaited_out.size(), e);
					n++;
				end
				if (n > 0) begin
					awaited_out[awaited_out.size()-1].is_last = 1'b1;
					repeat (n) begin
						shadow_time.delete(0);
						shadow_data.delete(0);
					end
				end
			end
			trbq_pkg::KIND_REBASE: begin
				foreach (shadow_time[i])
					shadow_time[i] = (shadow_time[i] > tv) ? shadow_time[i] - tv : '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input logic [trbq_pkg::KIND_W-1:0] k,
			input logic [trbq_pkg::TIME_W-1:0] tv, input logic [trbq_pkg::BYTE_W-1:0] b,
			input logic fb);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		kind <= k;
		time_value <= tv;
		data_byte <= b;
		final_byte <= fb;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		order_and_release(k, tv, b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [trbq_pkg::TIME_W-1:0] pick_time(
			input logic [trbq_pkg::TIME_W-1:0] base);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return base + $urandom_range(0, 40);
		endcase
	endfunction

	// ties keep arrival order, empty and partial pumps
	task automatic test_order_ties();
		send_item(trbq_pkg::KIND_PUMP, 32'd0, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'd5, 8'hff, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'd3, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'd3, 8'h5a, 1'b1);
		send_item(trbq_pkg::KIND_PUSH, 32'd9, 8'ha5, 1'b1);
		send_item(trbq_pkg::KIND_PUSH, 32'hffff_ffff, 8'h81, 1'b0);
		send_item(trbq_pkg::KIND_PUMP, 32'd4, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUMP, 32'd8, 8'hff, 1'b1);
		send_item(KIND_UNUSED, 32'hffff_ffff, 8'hff, 1'b1);
		send_item(trbq_pkg::KIND_PUMP, 32'hffff_ffff, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUMP, 32'hffff_ffff, 8'h00, 1'b0);
	endtask

	// rebase saturates at zero and keeps order of equal times
	task automatic test_rebase_saturate();
		send_item(trbq_pkg::KIND_PUSH, 32'd0, 8'h01, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'd100, 8'h02, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'd60, 8'h03, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'hffff_ffff, 8'h04, 1'b1);
		send_item(trbq_pkg::KIND_REBASE, 32'd50, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_REBASE, 32'd0, 8'hff, 1'b1);
		send_item(trbq_pkg::KIND_PUMP, 32'd9, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUSH, 32'd0, 8'h05, 1'b0);
		send_item(trbq_pkg::KIND_REBASE, 32'hffff_ffff, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUMP, 32'd0, 8'h00, 1'b0);
	endtask

	// fill to capacity, push into a full queue, then empty it
	task automatic test_full_queue();
		send_item(trbq_pkg::KIND_PUMP, 32'hffff_ffff, 8'h00, 1'b0);
		repeat (DEPTH + 3)
			send_item(trbq_pkg::KIND_PUSH, $urandom_range(0, 20), 8'($urandom), 1'($urandom));
		send_item(trbq_pkg::KIND_PUMP, 32'd10, 8'h00, 1'b0);
		send_item(trbq_pkg::KIND_PUMP, 32'hffff_ffff, 8'h00, 1'b0);
	endtask

	task automatic test_random_traffic(input int count);
		int sent;
		int burst;
		logic [trbq_pkg::TIME_W-1:0] base;
		sent = 0;
		base = $urandom_range(0, 1000);
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					burst = $urandom_range(1, 8);
					for (int i = 0; i < burst; i++)
						send_item(trbq_pkg::KIND_PUSH, pick_time(base), 8'($urandom),
							(i == burst - 1) ^ ($urandom_range(0, 7) == 0));
					if ($urandom_range(0, 7) == 0)
						send_item(trbq_pkg::KIND_PUMP, 32'hffff_ffff, 8'($urandom),
							1'($urandom));
					else
						send_item(trbq_pkg::KIND_PUMP, base + $urandom_range(0, 50),
							8'($urandom), 1'($urandom));
					sent += burst + 1;
					base += $urandom_range(0, 30);
				end
				6: begin
					if ($urandom_range(0, 3) == 0)
						send_item(trbq_pkg::KIND_REBASE, $urandom, 8'($urandom),
							1'($urandom));
					else
						send_item(trbq_pkg::KIND_REBASE, $urandom_range(0, 60), 8'($urandom),
							1'($urandom));
					sent++;
				end
				7: begin
					send_item(KIND_UNUSED, $urandom, 8'($urandom), 1'($urandom));
					sent++;
				end
				8: begin
					send_item(trbq_pkg::KIND_PUMP, pick_time(base), 8'($urandom),
						1'($urandom));
					sent++;
				end
				default: begin
					send_item(trbq_pkg::KIND_PUSH, $urandom, 8'($urandom), 1'($urandom));
					sent++;
				end
			endcase
		end
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_out.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual byte %h last %b ovf %b",
					$time, out_byte, last_released, overflow);
				err_count++;
			end else begin
				head_emit = awaited_out[0];
				awaited_out.delete(0);
				if (out_byte !== head_emit.data) begin
					$display("%0t out_byte mismatch: expected %h actual %h",
						$time, head_emit.data, out_byte);
					err_count++;
				end
				if (last_released !== head_emit.is_last) begin
					$display("%0t last_released mismatch: expected %b actual %b",
						$time, head_emit.is_last, last_released);
					err_count++;
				end
				if (overflow !== head_emit.is_ovf) begin
					$display("%0t overflow mismatch: expected %b actual %b",
						$time, head_emit.is_ovf, overflow);
					err_count++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		#2000000;
		$display("timestamped_byte_release_queue_top test failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 12;
		recv_stall_pct = 81;
		test_order_ties();
		test_rebase_saturate();
		test_full_queue();
		test_random_traffic(45);
		wait_drained();

		send_idle_pct = 81;
		recv_stall_pct = 12;
		test_random_traffic(60);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(60);
		wait_drained();
		repeat (8) @(posedge clk);

		if (awaited_out.size() != 0) begin
			$display("%0t %0d transfers never arrived", $time, awaited_out.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("timestamped_byte_release_queue_top test passed");
		end else begin
			$display("timestamped_byte_release_queue_top test failed");
		end
		$finish;
	end

endmodule
